// ===== rtl/gfba_pkg.sv =====
// ----------------------------------------------------------------------------
// gfba_pkg
// Shared sizes, codes and types of the grouped free-block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package gfba_pkg;

  // Geometry of the free list
  localparam int unsigned GROUP_SIZE  = 50;
  localparam int unsigned NUM_BLOCKS  = 1024;
  localparam int unsigned MAX_REQUEST = 16;

  localparam int unsigned LINK_DEPTH = NUM_BLOCKS * GROUP_SIZE;

  // Field and state widths
  localparam int unsigned BLK_W   = $clog2(NUM_BLOCKS);
  localparam int unsigned CNT_W   = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned SP_W    = $clog2(GROUP_SIZE);
  localparam int unsigned J_W     = $clog2(GROUP_SIZE + 1);
  localparam int unsigned LINK_AW = $clog2(LINK_DEPTH);
  localparam int unsigned REQ_W   = 5;
  localparam int unsigned REM_W   = $clog2(MAX_REQUEST + 1);

  // Item kinds
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // Result status
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_e;

endpackage

`default_nettype wire

// ===== rtl/gfba_ram.sv =====
// ----------------------------------------------------------------------------
// gfba_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gfba_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/grouped_free_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// grouped_free_block_allocator_core
// Grouped free-list block allocator: a free stack in front of a link memory
// that chains groups of free block numbers through their leader blocks.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake                 | Word
//  --------+---------------------------+----------------------------------------
//  in      | in_valid_i / in_ready_o   | mode, block_count, freed_block
//  out     | out_valid_o / out_ready_i | block_number, status, free_blocks, last
//
//  Steps: a block popped from the stack is decided, read and emitted; a pop
//  that loads a group first moves the group over the single link memory
//  port, one entry a cycle. A plain free is pushed straight from idle; a
//  free that spills the full stack moves it over the same port.
//  Reset: the stack holds only the terminator, the free count is zero; the
//  link memory is not cleared. in_ready_o is high only while idle; a result
//  word waiting in the output register does not hold off a new item.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_free_block_allocator_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // input word
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       mode_i,
  input  wire logic [gfba_pkg::REQ_W-1:0] block_count_i,
  input  wire logic [gfba_pkg::BLK_W-1:0] freed_block_i,
  // result word
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic      [gfba_pkg::BLK_W-1:0] block_number_o,
  output logic      [1:0]                 status_o,
  output logic      [gfba_pkg::CNT_W-1:0] free_blocks_o,
  output logic                            last_o
);

  import gfba_pkg::*;

  localparam logic [SP_W-1:0] SP_MAX  = SP_W'(GROUP_SIZE - 1);
  localparam logic [J_W-1:0]  J_LAST  = J_W'(GROUP_SIZE - 1);
  localparam logic [J_W-1:0]  J_END   = J_W'(GROUP_SIZE);
  localparam logic [CNT_W-1:0] TOTAL_MAX = CNT_W'(NUM_BLOCKS);

  // One-hot sequencer
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_STEP  = 5'b00010,
    S_POP   = 5'b00100,
    S_LOAD  = 5'b01000,
    S_SPILL = 5'b10000
  } state_e;

  // Pending result waits here in S_EMIT-like fashion: the emit happens from
  // the flag res_pend_q so that every working state can hand a word over.
  state_e            state_q, state_d;
  logic [SP_W-1:0]   sp_q, sp_d;
  logic [BLK_W-1:0]  bottom_q, bottom_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [REM_W-1:0]  remain_q, remain_d;
  logic [BLK_W-1:0]  freed_q, freed_d;
  logic [J_W-1:0]    j_q, j_d;
  logic [LINK_AW-1:0] addr_q, addr_d;

  logic              res_pend_q, res_pend_d;
  logic [BLK_W-1:0]  res_blk_q, res_blk_d;
  status_e           res_status_q, res_status_d;
  logic              res_last_q, res_last_d;

  logic              out_valid_q, out_valid_d;
  logic [BLK_W-1:0]  out_blk_q, out_blk_d;
  status_e           out_status_q, out_status_d;
  logic [CNT_W-1:0]  out_total_q, out_total_d;
  logic              out_last_q, out_last_d;

  // Memory ports
  logic              stk_we, stk_re;
  logic [SP_W-1:0]   stk_waddr, stk_raddr;
  logic [BLK_W-1:0]  stk_wdata, stk_rdata;
  logic              lnk_we, lnk_re;
  logic [LINK_AW-1:0] lnk_waddr, lnk_raddr;
  logic [BLK_W-1:0]  lnk_wdata, lnk_rdata;

  logic              in_acc;
  logic              out_free;
  logic [REQ_W-1:0]  req_clamped;
  logic              bad_free;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign req_clamped = (block_count_i > REQ_W'(MAX_REQUEST)) ? REQ_W'(MAX_REQUEST)
                                                             : block_count_i;
  assign bad_free = (freed_block_i == '0) ||
                    (CNT_W'(freed_block_i) >= TOTAL_MAX);

  // Ready only when idle and no word is still queued for the output.
  assign in_ready_o = (state_q == S_IDLE) && !res_pend_q;

  // Entry 0 of the stack lives in bottom_q; entries 1.. live in the RAM.
  gfba_ram #(
    .DEPTH (GROUP_SIZE),
    .WIDTH (BLK_W)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // Link memory: GROUP_SIZE slots per block, no reset.
  gfba_ram #(
    .DEPTH (LINK_DEPTH),
    .WIDTH (BLK_W)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lnk_we),
    .waddr_i (lnk_waddr),
    .wdata_i (lnk_wdata),
    .re_i    (lnk_re),
    .raddr_i (lnk_raddr),
    .rdata_o (lnk_rdata)
  );

  always_comb begin
    state_d      = state_q;
    sp_d         = sp_q;
    bottom_d     = bottom_q;
    total_d      = total_q;
    remain_d     = remain_q;
    freed_d      = freed_q;
    j_d          = j_q;
    addr_d       = addr_q;
    res_pend_d   = res_pend_q;
    res_blk_d    = res_blk_q;
    res_status_d = res_status_q;
    res_last_d   = res_last_q;
    out_valid_d  = out_valid_q;
    out_blk_d    = out_blk_q;
    out_status_d = out_status_q;
    out_total_d  = out_total_q;
    out_last_d   = out_last_q;

    stk_we    = 1'b0;
    stk_waddr = sp_q + 1'b1;
    stk_wdata = freed_block_i;
    stk_re    = 1'b0;
    stk_raddr = sp_q;
    lnk_we    = 1'b0;
    lnk_waddr = addr_q;
    lnk_wdata = (j_q == '0) ? bottom_q : stk_rdata;
    lnk_re    = 1'b0;
    lnk_raddr = addr_q;

    // Output register: drop the word once taken.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Hand a pending result to the output register; the free count is
    // already updated for it.
    if (res_pend_q && out_free) begin
      out_valid_d  = 1'b1;
      out_blk_d    = res_blk_q;
      out_status_d = res_status_q;
      out_total_d  = total_q;
      out_last_d   = res_last_q;
      res_pend_d   = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          freed_d  = freed_block_i;
          remain_d = REM_W'(req_clamped);
          if (mode_i == MODE_FREE) begin
            res_blk_d  = '0;
            res_last_d = 1'b1;
            if (bad_free) begin
              res_status_d = ST_BAD_FREE;
              res_pend_d   = 1'b1;
            end else if (sp_q == SP_MAX) begin
              // Full stack: spill it into the freed block's slots.
              addr_d  = LINK_AW'(freed_block_i) * LINK_AW'(GROUP_SIZE);
              j_d     = '0;
              state_d = S_SPILL;
            end else begin
              stk_we       = 1'b1;
              sp_d         = sp_q + 1'b1;
              total_d      = (total_q < TOTAL_MAX) ? total_q + 1'b1 : total_q;
              res_status_d = ST_OK;
              res_pend_d   = 1'b1;
            end
          end else if (req_clamped != '0) begin
            state_d = S_STEP;
          end
        end
      end

      S_STEP: begin
        // Wait until the previous word has left the pending slot.
        if (!res_pend_q) begin
          if (sp_q == '0) begin
            if (bottom_q == '0) begin
              res_blk_d    = '0;
              res_status_d = ST_NO_SPACE;
              res_last_d   = 1'b1;
              res_pend_d   = 1'b1;
              state_d      = S_IDLE;
            end else begin
              // Leader block: load its group, then hand it out.
              res_blk_d = bottom_q;
              addr_d    = LINK_AW'(bottom_q) * LINK_AW'(GROUP_SIZE);
              j_d       = '0;
              state_d   = S_LOAD;
            end
          end else begin
            stk_re  = 1'b1;
            state_d = S_POP;
          end
        end
      end

      S_POP: begin
        res_blk_d    = stk_rdata;
        res_status_d = ST_OK;
        res_last_d   = (remain_q == REM_W'(1));
        res_pend_d   = 1'b1;
        sp_d         = sp_q - 1'b1;
        total_d      = (total_q != '0) ? total_q - 1'b1 : total_q;
        remain_d     = remain_q - 1'b1;
        state_d      = (remain_q == REM_W'(1)) ? S_IDLE : S_STEP;
      end

      S_LOAD: begin
        // Read slot j, write slot j-1 from the data read last cycle.
        if (j_q != J_END) begin
          lnk_re = 1'b1;
          addr_d = addr_q + 1'b1;
        end
        if (j_q == J_W'(1)) begin
          bottom_d = lnk_rdata;
        end else if (j_q != '0) begin
          stk_we    = 1'b1;
          stk_waddr = SP_W'(j_q - 1'b1);
          stk_wdata = lnk_rdata;
        end
        j_d = j_q + 1'b1;
        if (j_q == J_END) begin
          sp_d         = SP_MAX;
          total_d      = (total_q != '0) ? total_q - 1'b1 : total_q;
          res_status_d = ST_OK;
          res_last_d   = (remain_q == REM_W'(1));
          res_pend_d   = 1'b1;
          remain_d     = remain_q - 1'b1;
          state_d      = (remain_q == REM_W'(1)) ? S_IDLE : S_STEP;
        end
      end

      S_SPILL: begin
        // Write slot j; entry 0 from bottom_q, others from the stack RAM
        // read issued the cycle before.
        lnk_we = 1'b1;
        addr_d = addr_q + 1'b1;
        if (j_q != J_LAST) begin
          stk_re    = 1'b1;
          stk_raddr = SP_W'(j_q + 1'b1);
        end
        j_d = j_q + 1'b1;
        if (j_q == J_LAST) begin
          bottom_d     = freed_q;
          sp_d         = '0;
          total_d      = (total_q < TOTAL_MAX) ? total_q + 1'b1 : total_q;
          res_status_d = ST_OK;
          res_pend_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      bottom_q    <= '0;
      total_q     <= '0;
      remain_q    <= '0;
      j_q         <= '0;
      res_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      bottom_q    <= bottom_d;
      total_q     <= total_d;
      remain_q    <= remain_d;
      j_q         <= j_d;
      res_pend_q  <= res_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    freed_q      <= freed_d;
    addr_q       <= addr_d;
    res_blk_q    <= res_blk_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
    out_blk_q    <= out_blk_d;
    out_status_q <= out_status_d;
    out_total_q  <= out_total_d;
    out_last_q   <= out_last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign block_number_o = out_blk_q;
  assign status_o       = out_status_q;
  assign free_blocks_o  = out_total_q;
  assign last_o         = out_last_q;

`ifndef ASSERT_OFF
  a_sp_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_MAX)
    else $error("stack pointer beyond group size");

  a_total_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TOTAL_MAX)
    else $error("free count above block count");

  a_error_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> last_o && (block_number_o == '0))
    else $error("error word not final or carries a block");

  a_load_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STEP) && !res_pend_q && (sp_q == '0) && (bottom_q != '0)
    |=> (state_q == S_LOAD) && (j_q == '0))
    else $error("group load not started on leader pop");

  a_spill_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SPILL) && (j_q == J_LAST) |=> (sp_q == '0) && res_pend_q)
    else $error("spill did not restart the stack");
`endif

endmodule

`default_nettype wire

// ===== dv/gfba_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfba_checker
// Watches both channels of the allocator, keeps its own copy of the free
// stack, the group link memory and the free count, and checks every result
// word against the oldest predicted one.
// ----------------------------------------------------------------------------

module gfba_checker
  import gfba_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic             mode_i,
  input  logic [REQ_W-1:0] block_count_i,
  input  logic [BLK_W-1:0] freed_block_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [BLK_W-1:0] block_number_i,
  input  logic [1:0]       status_i,
  input  logic [CNT_W-1:0] free_blocks_i,
  input  logic             last_i,
  output int               fail_count_o,
  output int               due_count_o
);

  typedef struct packed {
    logic [BLK_W-1:0] blk;
    status_e          st;
    logic [CNT_W-1:0] free;
    logic             last;
  } alloc_word_t;

  alloc_word_t      due_words[$];
  logic [BLK_W-1:0] free_stack_m[GROUP_SIZE];
  logic [BLK_W-1:0] group_links_m[LINK_DEPTH];
  int unsigned      top_idx;
  int unsigned      free_cnt;
  int               mismatches;

  function automatic void queue_result(logic [BLK_W-1:0] blk, status_e st, logic last);
    alloc_word_t w;
    w.blk  = blk;
    w.st   = st;
    w.free = CNT_W'(free_cnt);
    w.last = last;
    due_words.push_back(w);
  endfunction

  // Advance the allocator state by one request and queue the words it yields.
  function automatic void predict_allocation(logic m, logic [REQ_W-1:0] cnt,
                                             logic [BLK_W-1:0] freed);
    int unsigned      want;
    int unsigned      base;
    int unsigned      k;
    int unsigned      j;
    logic [BLK_W-1:0] got;
    if (m == MODE_FREE) begin
      if (freed == '0 || freed >= NUM_BLOCKS) begin
        queue_result('0, ST_BAD_FREE, 1'b1);
        return;
      end
      if (top_idx == GROUP_SIZE - 1) begin
        // spill the full stack into the freed block's link slots
        base = freed * GROUP_SIZE;
        for (j = 0; j < GROUP_SIZE; j++) group_links_m[base + j] = free_stack_m[j];
        free_stack_m[0] = freed;
        top_idx = 0;
      end else begin
        top_idx++;
        free_stack_m[top_idx] = freed;
      end
      if (free_cnt < NUM_BLOCKS) free_cnt++;
      queue_result('0, ST_OK, 1'b1);
      return;
    end
    want = (cnt > MAX_REQUEST) ? MAX_REQUEST : cnt;
    for (k = 0; k < want; k++) begin
      if (top_idx == 0) begin
        got = free_stack_m[0];
        if (got == '0) begin
          queue_result('0, ST_NO_SPACE, 1'b1);
          return;
        end
        // the leader hands over its group, then goes out itself
        base = got * GROUP_SIZE;
        for (j = 0; j < GROUP_SIZE; j++) free_stack_m[j] = group_links_m[base + j];
        top_idx = GROUP_SIZE - 1;
      end else begin
        got = free_stack_m[top_idx];
        top_idx--;
      end
      if (free_cnt > 0) free_cnt--;
      queue_result(got, ST_OK, (k + 1 == want));
    end
  endfunction

  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_word_t w;
    if (!rst_ni) begin
      for (int i = 0; i < GROUP_SIZE; i++) free_stack_m[i] = '0;
      top_idx    = 0;
      free_cnt   = 0;
      mismatches = 0;
      due_words.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_words.size() == 0) begin
          $display("%0t: result word with none expected, block_number %0d status %0d",
                   $time, block_number_i, status_i);
          mismatches++;
        end else begin
          w = due_words.pop_front();
          compare_field("block_number", w.blk, block_number_i);
          compare_field("status", w.st, status_i);
          compare_field("free_blocks", w.free, free_blocks_i);
          compare_field("last", w.last, last_i);
        end
      end
      if (in_valid_i && in_ready_i) predict_allocation(mode_i, block_count_i, freed_block_i);
    end
    fail_count_o <= mismatches;
    due_count_o  <= due_words.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the grouped free-block allocator: directed corner
// requests, then random runs of frees and allocations with bursty idling on
// both channels; a checker beside the block predicts and compares each word.
// ----------------------------------------------------------------------------

module tb;
  import gfba_pkg::*;

  // Generous ceiling: worst case per request is sixteen words each waiting
  // out a full stall, plus a group load and a sender gap, times ~170 requests.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             mode_i;
  logic [REQ_W-1:0] block_count_i;
  logic [BLK_W-1:0] freed_block_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [BLK_W-1:0] block_number_o;
  logic [1:0]       status_o;
  logic [CNT_W-1:0] free_blocks_o;
  logic             last_o;

  int               fail_count;
  int               due_count;
  int unsigned      cycle_count = 0;
  int unsigned      issued      = 0;
  bit               idling      = 1'b1;  // random gaps and stalls allowed

  grouped_free_block_allocator_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .mode_i         (mode_i),
    .block_count_i  (block_count_i),
    .freed_block_i  (freed_block_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .block_number_o (block_number_o),
    .status_o       (status_o),
    .free_blocks_o  (free_blocks_o),
    .last_o         (last_o)
  );

  gfba_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .mode_i         (mode_i),
    .block_count_i  (block_count_i),
    .freed_block_i  (freed_block_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .block_number_i (block_number_o),
    .status_i       (status_o),
    .free_blocks_i  (free_blocks_o),
    .last_i         (last_o),
    .fail_count_o   (fail_count),
    .due_count_o    (due_count)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL grouped_free_block_allocator_core");
      $finish;
    end
  end

  // Result side: hold ready low for random bursts while idling is on; the
  // burst length is fixed when it starts so it always runs out.
  initial begin
    int unsigned stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left == 0 && idling && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 17);
      out_ready_i <= (stall_left == 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // Offer one request word and hold it, unchanged, until the block takes it.
  // Entered and left at a falling edge; valid is only dropped for a gap, so
  // back-to-back words keep valid high without a glitch.
  task automatic issue_word(input logic m, input logic [REQ_W-1:0] cnt,
                            input logic [BLK_W-1:0] blk);
    int unsigned gap;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= m;
    block_count_i <= cnt;
    freed_block_i <= blk;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    issued++;
    @(negedge clk_i);
  endtask

  // Mostly valid frees, the odd block 0 among them; block_count is noise here.
  task automatic fill_run(input int unsigned n);
    repeat (n)
      issue_word(MODE_FREE, REQ_W'($urandom),
                 ($urandom_range(0, 15) == 0) ? BLK_W'(0) : BLK_W'($urandom_range(1, 1023)));
  endtask

  // Allocations over the whole count field: zero, in range and oversized.
  task automatic drain_run(input int unsigned n);
    repeat (n)
      issue_word(MODE_ALLOC,
                 ($urandom_range(0, 11) == 0) ? REQ_W'(0) : REQ_W'($urandom_range(1, 31)),
                 BLK_W'($urandom));
  endtask

  // Fully random words, all bits free.
  task automatic noise_run(input int unsigned n);
    repeat (n) issue_word(1'($urandom), REQ_W'($urandom), BLK_W'($urandom));
  endtask

  initial begin
    int unsigned pick;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    mode_i        = MODE_ALLOC;
    block_count_i = '0;
    freed_block_i = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed corners. The stack starts with only the terminator.
    issue_word(MODE_ALLOC, REQ_W'(1), BLK_W'(0));      // out of space at once
    issue_word(MODE_ALLOC, REQ_W'(0), BLK_W'(1023));   // zero count: no words
    issue_word(MODE_FREE, REQ_W'(31), BLK_W'(0));      // invalid free
    issue_word(MODE_FREE, REQ_W'(0), BLK_W'(1023));    // highest block
    issue_word(MODE_FREE, REQ_W'(16), BLK_W'(1));
    issue_word(MODE_FREE, REQ_W'(21), BLK_W'(682));    // alternating bits
    issue_word(MODE_FREE, REQ_W'(10), BLK_W'(341));
    issue_word(MODE_ALLOC, REQ_W'(2), BLK_W'(0));
    issue_word(MODE_ALLOC, REQ_W'(31), BLK_W'(1023));  // oversized, runs dry midway
    issue_word(MODE_FREE, REQ_W'(1), BLK_W'(512));
    issue_word(MODE_ALLOC, REQ_W'(16), BLK_W'(5));     // one block, then dry
    issue_word(MODE_ALLOC, REQ_W'(17), BLK_W'(1023));  // clamped count, dry
    issue_word(MODE_FREE, REQ_W'(31), BLK_W'(5));
    issue_word(MODE_FREE, REQ_W'(0), BLK_W'(6));
    issue_word(MODE_ALLOC, REQ_W'(0), BLK_W'(0));
    issue_word(MODE_ALLOC, REQ_W'(1), BLK_W'(0));
    issue_word(MODE_ALLOC, REQ_W'(16), BLK_W'(0));

    // Random core: first fill past one spill and drain through a group load,
    // then mixed runs, each with idling switched on or off.
    fill_run(60);
    drain_run(8);
    while (issued < 110) begin
      idling = ($urandom_range(0, 3) != 0);
      pick   = $urandom_range(0, 9);
      if (pick < 4)      fill_run($urandom_range(5, 20));
      else if (pick < 7) drain_run($urandom_range(2, 8));
      else               noise_run($urandom_range(3, 12));
    end

    // Quiet tail: no gaps and no stalls
    idling = 1'b0;
    noise_run(20);
    fill_run(12);
    drain_run(6);
    in_valid_i <= 1'b0;

    while (due_count != 0) @(posedge clk_i);
    repeat (GROUP_SIZE + 10) @(posedge clk_i);

    if (fail_count == 0 && due_count == 0) begin
      $display("PASS grouped_free_block_allocator_core");
    end else begin
      $display("FAIL grouped_free_block_allocator_core");
    end
    $finish;
  end

endmodule
